### sv/mjdcal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mjdcal_pkg
// Constants and helper functions for the modified julian date converter.
// ----------------------------------------------------------------------------
package mjdcal_pkg;

   localparam int MJD_W   = 17;
   localparam int YEAR_W  = 8;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;

   // Dates outside 1900-03-01 .. 2100-02-28 are flagged.
   localparam logic [MJD_W-1:0] MJD_LOW  = 17'd15079;
   localparam logic [MJD_W-1:0] MJD_HIGH = 17'd88127;

   // floor((100*mjd - 1507820) / 36525) equals floor((4*mjd - 60313) / 1461)
   // for every valid date, since the dropped fraction never crosses a step.
   localparam int NUM_W = 19;
   localparam logic [NUM_W-1:0] N_OFFSET = 19'd60313;
   localparam logic [NUM_W-1:0] YEAR_DIV = 19'd1461;

   // Reciprocal of 1461 scaled by 2**28, rounded down. The estimate it gives
   // is the true quotient or one below it.
   localparam int RECIP_W     = 18;
   localparam int RECIP_SHIFT = 28;
   localparam logic [RECIP_W-1:0] RECIP = 18'd183734;
   localparam int PROD_W = NUM_W + RECIP_W;

   localparam int REM_W   = 12;
   localparam int DAYS_W  = 9;
   localparam logic [MJD_W-1:0] M_BASE = 17'd14956;

   localparam int MP_W   = 4;
   localparam int MP_MAX = 15;

   // Smallest day remainder for which M' reaches j:
   // ceil((30.6001*j + 0.1) * 10000 / 10000).
   function automatic logic [DAYS_W-1:0] month_thr(input int j);
      month_thr = DAYS_W'((j * 306001 + 1000 + 9999) / 10000);
   endfunction

   // floor(j * 30.6001)
   function automatic logic [DAYS_W-1:0] month_days(input int j);
      month_days = DAYS_W'((j * 306001) / 10000);
   endfunction

endpackage
`default_nettype wire

### sv/mjd_to_calendar_date.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mjd_to_calendar_date
// Converts a modified julian day number to year since 1900, month and day.
// ----------------------------------------------------------------------------
// The converter is a seven-stage pipeline that takes one beat per cycle and
// passes each beat through stages 1 to 6 into the output register. All
// stages share one advance enable: while a finished result is held by
// rsp_stall, the whole pipeline holds and req_stall is raised, so the rate is
// one beat per cycle whenever the result side keeps taking beats. The year
// quotient comes from a reciprocal multiply with a one-step correction, and
// the month from a row of parallel threshold compares.
module mjd_to_calendar_date
   import mjdcal_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic [MJD_W-1:0]   req_mjd,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [YEAR_W-1:0]  rsp_year_since_1900,
   output      logic [MONTH_W-1:0] rsp_month,
   output      logic [DAY_W-1:0]   rsp_day,
   output      logic               rsp_out_of_range
);

   logic adv;

   // Stage valid bits.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, s6_valid_ff;
   logic rsp_valid_ff;

   // Stage 1: range check and numerator.
   logic [MJD_W-1:0] s1_mjd_ff;
   logic             s1_oor_ff, s1_oor_in;
   logic [NUM_W-1:0] s1_n_ff, s1_n_in;

   // Stage 2: reciprocal product.
   logic [MJD_W-1:0]  s2_mjd_ff;
   logic              s2_oor_ff;
   logic [NUM_W-1:0]  s2_n_ff;
   logic [PROD_W-1:0] s2_p_ff, s2_p_in;

   // Stage 3: quotient estimate and its remainder.
   logic [MJD_W-1:0]  s3_mjd_ff;
   logic              s3_oor_ff;
   logic [YEAR_W-1:0] s3_q_ff, s3_q_in;
   logic [REM_W-1:0]  s3_r_ff, s3_r_in;

   // Stage 4: corrected year quotient Y'.
   logic [MJD_W-1:0]  s4_mjd_ff;
   logic              s4_oor_ff;
   logic [YEAR_W-1:0] s4_yp_ff, s4_yp_in;

   // Stage 5: days into the shifted year.
   logic              s5_oor_ff;
   logic [YEAR_W-1:0] s5_yp_ff;
   logic [DAYS_W-1:0] s5_rem_ff, s5_rem_in;

   // Stage 6: month quotient M' and day.
   logic              s6_oor_ff;
   logic [YEAR_W-1:0] s6_yp_ff;
   logic [MP_W-1:0]   s6_mp_ff, s6_mp_in;
   logic [DAY_W-1:0]  s6_day_ff, s6_day_in;

   // Output register.
   logic [YEAR_W-1:0]  rsp_year_ff, rsp_year_in;
   logic [MONTH_W-1:0] rsp_month_ff, rsp_month_in;
   logic [DAY_W-1:0]   rsp_day_ff, rsp_day_in;
   logic               rsp_oor_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   always_comb begin
      logic [NUM_W-1:0]  prod_q;
      logic [NUM_W-1:0]  diff_r;
      logic [MJD_W-1:0]  ydays;
      logic [MJD_W-1:0]  rem_full;
      logic [DAYS_W-1:0] mdays;
      logic              k;

      // Stage 1
      s1_oor_in = (req_mjd < MJD_LOW) || (req_mjd > MJD_HIGH);
      s1_n_in   = {req_mjd, 2'b00} - N_OFFSET;

      // Stage 2
      s2_p_in = PROD_W'(s1_n_ff) * PROD_W'(RECIP);

      // Stage 3
      s3_q_in = s2_p_ff[RECIP_SHIFT +: YEAR_W];
      prod_q  = NUM_W'(s3_q_in) * YEAR_DIV;
      diff_r  = s2_n_ff - prod_q;
      s3_r_in = diff_r[REM_W-1:0];

      // Stage 4
      s4_yp_in = s3_q_ff + YEAR_W'(s3_r_ff >= REM_W'(YEAR_DIV));

      // Stage 5: floor(Y' * 365.25) is Y' * 365 plus Y' / 4.
      ydays     = MJD_W'(s4_yp_ff) * MJD_W'(365) + MJD_W'(s4_yp_ff[YEAR_W-1:2]);
      rem_full  = s4_mjd_ff - M_BASE - ydays;
      s5_rem_in = rem_full[DAYS_W-1:0];

      // Stage 6: the highest threshold reached gives M'.
      s6_mp_in = '0;
      mdays    = '0;
      for (int j = 1; j <= MP_MAX; j++) begin
         if (s5_rem_ff >= month_thr(j)) begin
            s6_mp_in = MP_W'(j);
            mdays    = month_days(j);
         end
      end
      s6_day_in = DAY_W'(s5_rem_ff - mdays);

      // Stage 7: M' of 14 or 15 stands for January or February of next year.
      k = (s6_mp_ff == MP_W'(14)) || (s6_mp_ff == MP_W'(15));
      if (s6_oor_ff) begin
         rsp_year_in  = '0;
         rsp_month_in = '0;
         rsp_day_in   = '0;
      end else begin
         rsp_year_in  = s6_yp_ff + YEAR_W'(k);
         rsp_month_in = s6_mp_ff - MONTH_W'(1) - (k ? MONTH_W'(12) : MONTH_W'(0));
         rsp_day_in   = s6_day_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         rsp_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_mjd_ff    <= req_mjd;
         s1_oor_ff    <= s1_oor_in;
         s1_n_ff      <= s1_n_in;

         s2_mjd_ff    <= s1_mjd_ff;
         s2_oor_ff    <= s1_oor_ff;
         s2_n_ff      <= s1_n_ff;
         s2_p_ff      <= s2_p_in;

         s3_mjd_ff    <= s2_mjd_ff;
         s3_oor_ff    <= s2_oor_ff;
         s3_q_ff      <= s3_q_in;
         s3_r_ff      <= s3_r_in;

         s4_mjd_ff    <= s3_mjd_ff;
         s4_oor_ff    <= s3_oor_ff;
         s4_yp_ff     <= s4_yp_in;

         s5_oor_ff    <= s4_oor_ff;
         s5_yp_ff     <= s4_yp_ff;
         s5_rem_ff    <= s5_rem_in;

         s6_oor_ff    <= s5_oor_ff;
         s6_yp_ff     <= s5_yp_ff;
         s6_mp_ff     <= s6_mp_in;
         s6_day_ff    <= s6_day_in;

         rsp_year_ff  <= rsp_year_in;
         rsp_month_ff <= rsp_month_in;
         rsp_day_ff   <= rsp_day_in;
         rsp_oor_ff   <= s6_oor_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_year_since_1900 = rsp_year_ff;
   assign rsp_month           = rsp_month_ff;
   assign rsp_day             = rsp_day_ff;
   assign rsp_out_of_range    = rsp_oor_ff;

   // A flagged date carries all-zero fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |->
         rsp_year_since_1900 == '0 && rsp_month == '0 && rsp_day == '0)
      else $error("out-of-range beat with nonzero date fields");

   // A converted date is a real calendar date within the span.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_of_range |->
         rsp_month >= MONTH_W'(1) && rsp_month <= MONTH_W'(12) &&
         rsp_day >= DAY_W'(1) && rsp_year_since_1900 <= YEAR_W'(200))
      else $error("converted date out of calendar range");

   // The year quotient estimate leaves a remainder below twice the divisor.
   assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff && !s4_oor_ff |-> $past(s3_r_ff) < REM_W'(2) * REM_W'(YEAR_DIV) ||
         !$past(adv))
      else $error("year quotient estimate off by more than one");

   // The pipeline holds while the result beat is stalled.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(s6_valid_ff) && $stable(s1_valid_ff))
      else $error("pipeline moved while result was stalled");

endmodule
`default_nettype wire

### test/mjd_to_calendar_date_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjd_to_calendar_date_tb
// Feeds day numbers into the date converter and checks every result beat
// against an in-bench scaled-integer calculation of year, month and day.
// Runs a directed set of range edges and month/year/leap-day boundaries, then
// random dates in phases with and without idle cycles on both channels.
// ----------------------------------------------------------------------------
module mjd_to_calendar_date_tb;
   import mjdcal_pkg::*;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic               bad_date;
   } cal_date_type;

   // Broadcast formula coefficients, scaled so every floor is exact.
   localparam longint unsigned YEAR_OFS_X100  = 1507820;
   localparam longint unsigned YEAR_LEN_X100  = 36525;
   localparam longint unsigned MONTH_BASE     = 14956;
   localparam longint unsigned MONTH_FRAC_X1E4 = 1000;
   localparam longint unsigned MONTH_LEN_X1E4 = 306001;

   localparam int CYCLE_LIMIT = 300000;
   localparam int LONG_HOLD   = 64;
   localparam int SETTLE      = 20;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [MJD_W-1:0]   req_mjd = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [YEAR_W-1:0]  rsp_year_since_1900;
   logic [MONTH_W-1:0] rsp_month;
   logic [DAY_W-1:0]   rsp_day;
   logic               rsp_out_of_range;

   logic [MJD_W-1:0] mjd_pending[$];
   cal_date_type     dates_expected[$];

   int  send_idle_pct = 0;
   int  stall_pct = 0;
   int  hold_requests = 0;
   int  hold_seen = 0;
   int  hold_left = 0;
   logic req_taken = 1'b0;
   int  dates_queued = 0;
   int  results_checked = 0;
   int  flagged_results = 0;
   int  blocked_offers = 0;
   int  error_count = 0;
   int  cycle_count = 0;

   mjd_to_calendar_date uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mjd             (req_mjd),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_year_since_1900 (rsp_year_since_1900),
      .rsp_month           (rsp_month),
      .rsp_day             (rsp_day),
      .rsp_out_of_range    (rsp_out_of_range)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic cal_date_type calendar_of(input logic [MJD_W-1:0] mjd);
      longint unsigned m, yp, ydays, rem, mp, mdays, k;
      cal_date_type d;
      d = '0;
      m = mjd;
      if (mjd < MJD_LOW || mjd > MJD_HIGH) begin
         d.bad_date = 1'b1;
         return d;
      end
      yp    = (m * 100 - YEAR_OFS_X100) / YEAR_LEN_X100;
      ydays = (yp * YEAR_LEN_X100) / 100;
      rem   = m - MONTH_BASE - ydays;
      mp    = (rem * 10000 - MONTH_FRAC_X1E4) / MONTH_LEN_X1E4;
      mdays = (mp * MONTH_LEN_X1E4) / 10000;
      // M' of 14 or 15 stands for January or February of the next year.
      k = (mp == 14 || mp == 15) ? 1 : 0;
      d.year  = YEAR_W'(yp + k);
      d.month = MONTH_W'(mp - 1 - 12 * k);
      d.day   = DAY_W'(rem - mdays);
      return d;
   endfunction

   task automatic queue_date(input logic [MJD_W-1:0] mjd);
      mjd_pending.push_back(mjd);
      dates_queued++;
   endtask

   // Mostly valid dates, some hugging the range edges, some anywhere.
   function automatic logic [MJD_W-1:0] random_mjd();
      int pick;
      pick = $urandom_range(99);
      if (pick < 80)
         return MJD_W'($urandom_range(MJD_HIGH, MJD_LOW));
      else if (pick < 90)
         return ($urandom_range(1) != 0) ? MJD_W'(MJD_LOW - 3 + $urandom_range(6))
                                         : MJD_W'(MJD_HIGH - 3 + $urandom_range(6));
      else
         return MJD_W'($urandom);
   endfunction

   task automatic wait_drained();
      while (results_checked != dates_queued)
         @(negedge clock);
      @(posedge clock);
   endtask

   // Driver: a new beat is offered only once the previous one was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (mjd_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_mjd   <= mjd_pending.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result-side stall, including the long hold-off when one is requested.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_seen != hold_requests) begin
         hold_seen <= hold_requests;
         hold_left <= LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall)
         dates_expected.push_back(calendar_of(req_mjd));
      if (!reset && req_valid && req_stall)
         blocked_offers++;
   end

   always @(posedge clock) begin
      cal_date_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (dates_expected.size() == 0) begin
            error_count++;
            $display("%0t: result beat with nothing expected: year %0d month %0d day %0d flag %0b",
                     $time, rsp_year_since_1900, rsp_month, rsp_day, rsp_out_of_range);
         end else begin
            want = dates_expected.pop_front();
            results_checked++;
            if (want.bad_date)
               flagged_results++;
            if (rsp_year_since_1900 !== want.year) begin
               error_count++;
               $display("%0t: year_since_1900 expected %0d, got %0d",
                        $time, want.year, rsp_year_since_1900);
            end
            if (rsp_month !== want.month) begin
               error_count++;
               $display("%0t: month expected %0d, got %0d", $time, want.month, rsp_month);
            end
            if (rsp_day !== want.day) begin
               error_count++;
               $display("%0t: day expected %0d, got %0d", $time, want.day, rsp_day);
            end
            if (rsp_out_of_range !== want.bad_date) begin
               error_count++;
               $display("%0t: out_of_range expected %0b, got %0b",
                        $time, want.bad_date, rsp_out_of_range);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding",
                  cycle_count, dates_queued - results_checked);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      logic [MJD_W-1:0] edge_dates[$];
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Range limits, all-zero and all-one words, and calendar boundaries:
      // year ends, leap days, and the last days before 2100.
      edge_dates = '{17'd0, 17'd131071, 17'd15078, 17'd15079, 17'd15080,
                     17'd88126, 17'd88127, 17'd88128, 17'd43690, 17'd87381,
                     17'd65535, 17'd65536, 17'd15384, 17'd15385, 17'd15443,
                     17'd15444, 17'd16539, 17'd51543, 17'd51544, 17'd51603,
                     17'd51604, 17'd88068, 17'd88069};
      foreach (edge_dates[i])
         queue_date(edge_dates[i]);
      wait_drained();

      // Full rate, with one long result-side hold while beats keep coming.
      for (int i = 0; i < 200; i++)
         queue_date(random_mjd());
      hold_requests++;
      wait_drained();

      send_idle_pct = 81;
      for (int i = 0; i < 180; i++)
         queue_date(random_mjd());
      wait_drained();

      send_idle_pct = 0;
      stall_pct = 81;
      for (int i = 0; i < 180; i++)
         queue_date(random_mjd());
      wait_drained();

      send_idle_pct = 31;
      stall_pct = 31;
      for (int i = 0; i < 180; i++)
         queue_date(random_mjd());
      wait_drained();

      stall_pct = 0;
      repeat (SETTLE) @(negedge clock);

      $display("Checked %0d dates (%0d flagged out of range) over directed and random phases;",
               results_checked, flagged_results);
      $display("input was held off on %0d offered beats during result-side stalls.",
               blocked_offers);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
